[src/ale_pkg.sv]
// Shared types and constants for the array list engine.
package ale_pkg;

  localparam int unsigned DEPTH_DEF  = 16;
  localparam int unsigned DATA_W_DEF = 32;

  localparam int unsigned OP_W   = 3;
  localparam int unsigned CNT_W  = 5;
  localparam int unsigned STS_W  = 2;
  localparam int unsigned CNT_MAX = (1 << CNT_W) - 1;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 3'd0,
    OP_APPEND = 3'd1,
    OP_REMOVE = 3'd2,
    OP_GET    = 3'd3,
    OP_UPDATE = 3'd4,
    OP_FIND   = 3'd5,
    OP_CLEAR  = 3'd6
  } opcode_e;

  typedef enum logic [STS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_WALK,
    S_GETW,
    S_FINAL,
    S_DONE
  } state_e;

  typedef struct packed {
    logic    busy;
    logic    done;
    logic    found;
    status_e status;
  } res_flags_t;

endpackage

[src/ale_mem.sv]
// Slot store: one write port, one read port with registered read data.
module ale_mem #(
  parameter int unsigned DEPTH  = ale_pkg::DEPTH_DEF,
  parameter int unsigned DATA_W = ale_pkg::DATA_W_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DATA_W-1:0]        wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DATA_W-1:0]        rdata_o
);
  import ale_pkg::*;

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/ale_seq.sv]
// Command sequencer: decodes a command and walks the slot store one slot a cycle.
module ale_seq #(
  parameter int unsigned DEPTH  = ale_pkg::DEPTH_DEF,
  parameter int unsigned DATA_W = ale_pkg::DATA_W_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [ale_pkg::OP_W-1:0]   opcode_i,
  input  logic [ale_pkg::CNT_W-1:0]  position_i,
  input  logic [DATA_W-1:0]          value_i,
  input  logic [ale_pkg::CNT_W-1:0]  capacity_i,
  input  logic                       cfg_we_i,
  input  logic [ale_pkg::CNT_W-1:0]  cfg_cap_i,
  output logic                       mem_we_o,
  output logic [$clog2(DEPTH)-1:0]   mem_waddr_o,
  output logic [DATA_W-1:0]          mem_wdata_o,
  output logic                       mem_re_o,
  output logic [$clog2(DEPTH)-1:0]   mem_raddr_o,
  input  logic [DATA_W-1:0]          mem_rdata_i,
  output logic [ale_pkg::CNT_W-1:0]  count_o,
  output logic [DATA_W-1:0]          read_value_o,
  output ale_pkg::res_flags_t        flags_o
);
  import ale_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam logic [DATA_W-1:0] EMPTY_WORD = {DATA_W{1'b1}};

  state_e                 state_q, state_d;
  logic [OP_W-1:0]        op_q, op_d;
  logic [CNT_W-1:0]       pos_q, pos_d;
  logic [DATA_W-1:0]      val_q, val_d;
  logic [CNT_W-1:0]       count_q, count_d;
  logic [CNT_W-1:0]       idx_q, idx_d;
  logic [CNT_W-1:0]       end_q, end_d;
  logic [CNT_W-1:0]       pidx_q, pidx_d;
  logic                   issue_q, issue_d;
  logic                   pend_q, pend_d;
  logic                   found_q, found_d;
  status_e                status_q, status_d;
  logic [DATA_W-1:0]      rd_q, rd_d;

  logic [CNT_W-1:0] pos_m1;
  logic             is_full;
  logic             ins_pos_ok;
  logic             in_count;
  logic             in_cap;
  logic             walk_down;
  logic [DATA_W-1:0] walk_word;

  assign pos_m1     = pos_q - CNT_W'(1);
  assign is_full    = (count_q >= capacity_i);
  assign ins_pos_ok = (pos_q != '0) &&
                      ({1'b0, pos_q} <= ({1'b0, count_q} + (CNT_W+1)'(1)));
  assign in_count   = (pos_q != '0) && (pos_q <= count_q);
  assign in_cap     = (pos_q != '0) && (pos_q <= capacity_i);
  assign walk_down  = (op_q == OP_INSERT);
  // slots at or above the fill count hold no entry and read as empty
  assign walk_word  = (pidx_q < count_q) ? mem_rdata_i : EMPTY_WORD;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_DONE;
        case (op_q)
          OP_INSERT: begin
            if (!is_full && ins_pos_ok) state_d = (pos_q <= count_q) ? S_WALK : S_FINAL;
          end
          OP_APPEND: begin
            if (!is_full) state_d = S_FINAL;
          end
          OP_REMOVE: begin
            if (in_count) state_d = (pos_q < count_q) ? S_WALK : S_FINAL;
          end
          OP_GET: begin
            if (in_cap) state_d = S_GETW;
          end
          OP_FIND: state_d = S_WALK;
          default: state_d = S_DONE;
        endcase
      end
      S_WALK: begin
        if (!issue_q) state_d = S_FINAL;
      end
      S_GETW:  state_d = S_DONE;
      S_FINAL: state_d = S_DONE;
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and store control
  always_comb begin
    op_d        = op_q;
    pos_d       = pos_q;
    val_d       = val_q;
    count_d     = count_q;
    idx_d       = idx_q;
    end_d       = end_q;
    pidx_d      = pidx_q;
    issue_d     = issue_q;
    pend_d      = 1'b0;
    found_d     = found_q;
    status_d    = status_q;
    rd_d        = rd_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = AW'(pos_m1);
    mem_wdata_o = val_q;
    mem_re_o    = 1'b0;
    mem_raddr_o = AW'(idx_q);

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          op_d  = opcode_i;
          pos_d = position_i;
          val_d = value_i;
        end
        // trim the list to a smaller capacity
        if (cfg_we_i && (count_q > cfg_cap_i)) count_d = cfg_cap_i;
      end
      S_EXEC: begin
        found_d  = 1'b0;
        rd_d     = '0;
        status_d = ST_OK;
        issue_d  = 1'b1;
        case (op_q)
          OP_INSERT: begin
            if (is_full)          status_d = ST_FULL;
            else if (!ins_pos_ok) status_d = ST_RANGE;
            idx_d = count_q - CNT_W'(1);
            end_d = pos_m1;
          end
          OP_APPEND: begin
            if (is_full) status_d = ST_FULL;
          end
          OP_REMOVE: begin
            if (!in_count) status_d = ST_RANGE;
            idx_d = pos_q;
            end_d = count_q - CNT_W'(1);
          end
          OP_GET: begin
            if (!in_cap) status_d = ST_RANGE;
            else begin
              mem_re_o    = 1'b1;
              mem_raddr_o = AW'(pos_m1);
            end
          end
          OP_UPDATE: begin
            if (!in_count) status_d = ST_RANGE;
            else           mem_we_o = 1'b1;
          end
          OP_FIND: begin
            idx_d = '0;
            end_d = capacity_i - CNT_W'(1);
          end
          OP_CLEAR: count_d = '0;
          default: ;
        endcase
      end
      S_WALK: begin
        // issue the next read
        if (issue_q) begin
          mem_re_o = 1'b1;
          pidx_d   = idx_q;
          pend_d   = 1'b1;
          if (idx_q == end_q) issue_d = 1'b0;
          else idx_d = walk_down ? (idx_q - CNT_W'(1)) : (idx_q + CNT_W'(1));
        end
        // retire the read issued last cycle
        if (pend_q) begin
          case (op_q)
            OP_INSERT: begin
              mem_we_o    = 1'b1;
              mem_waddr_o = AW'(pidx_q + CNT_W'(1));
              mem_wdata_o = mem_rdata_i;
            end
            OP_REMOVE: begin
              mem_we_o    = 1'b1;
              mem_waddr_o = AW'(pidx_q - CNT_W'(1));
              mem_wdata_o = mem_rdata_i;
            end
            OP_FIND: begin
              if (walk_word == val_q) found_d = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_GETW: begin
        rd_d = (pos_m1 < count_q) ? mem_rdata_i : EMPTY_WORD;
      end
      S_FINAL: begin
        case (op_q)
          OP_INSERT: begin
            mem_we_o = 1'b1;
            count_d  = count_q + CNT_W'(1);
          end
          OP_APPEND: begin
            mem_we_o    = 1'b1;
            mem_waddr_o = AW'(count_q);
            count_d     = count_q + CNT_W'(1);
          end
          OP_REMOVE: count_d = count_q - CNT_W'(1);
          default: ;
        endcase
      end
      S_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      issue_q  <= 1'b0;
      pend_q   <= 1'b0;
      found_q  <= 1'b0;
      status_q <= ST_OK;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      issue_q  <= issue_d;
      pend_q   <= pend_d;
      found_q  <= found_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    pos_q  <= pos_d;
    val_q  <= val_d;
    idx_q  <= idx_d;
    end_q  <= end_d;
    pidx_q <= pidx_d;
    rd_q   <= rd_d;
  end

  assign count_o       = count_q;
  assign read_value_o  = rd_q;
  assign flags_o.busy   = (state_q != S_IDLE);
  assign flags_o.done   = (state_q == S_DONE);
  assign flags_o.found  = found_q;
  assign flags_o.status = status_q;

endmodule

[src/array_list_engine_unit.sv]
// Throughput: one transaction at a time; busy stays high until the cycle after done_o.
// The walk reads one slot a cycle through the single read port of the slot store.
// Reset (async, active low): list empty, capacity min(5, DEPTH); store contents untouched,
// as slots at or above the fill count always read as empty. The receiver cannot stall.
module array_list_engine_unit #(
  parameter int unsigned DEPTH  = ale_pkg::DEPTH_DEF,
  parameter int unsigned DATA_W = ale_pkg::DATA_W_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic                              cfg_we_i,
  input  logic [ale_pkg::CNT_W-1:0]         cfg_wdata_i,
  input  logic [ale_pkg::OP_W-1:0]          opcode_i,
  input  logic [ale_pkg::CNT_W-1:0]         position_i,
  input  logic signed [DATA_W-1:0]          value_i,
  output logic                              done_o,
  output logic signed [DATA_W-1:0]          read_value_o,
  output logic                              found_o,
  output logic [ale_pkg::CNT_W-1:0]         count_o,
  output logic                              is_full_o,
  output logic                              is_empty_o,
  output logic [ale_pkg::STS_W-1:0]         status_o
);
  import ale_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  // capacity never exceeds the built depth nor what the count field can hold
  localparam logic [CNT_W-1:0] CAP_MAX = CNT_W'((DEPTH < CNT_MAX) ? DEPTH : CNT_MAX);
  localparam logic [CNT_W-1:0] CAP_RST = CNT_W'((DEPTH < 5) ? DEPTH : 5);

  logic [CNT_W-1:0]  capacity_q, capacity_d;
  logic [CNT_W-1:0]  count;
  logic [DATA_W-1:0] read_value;
  res_flags_t        flags;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [DATA_W-1:0] mem_rdata;

  // clamp the written capacity to 1..CAP_MAX
  always_comb begin
    capacity_d = capacity_q;
    if (cfg_we_i) begin
      if (cfg_wdata_i == '0)          capacity_d = CNT_W'(1);
      else if (cfg_wdata_i > CAP_MAX) capacity_d = CAP_MAX;
      else                            capacity_d = cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAP_RST;
    end else begin
      capacity_q <= capacity_d;
    end
  end

  ale_seq #(
    .DEPTH  (DEPTH),
    .DATA_W (DATA_W)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .opcode_i     (opcode_i),
    .position_i   (position_i),
    .value_i      (value_i),
    .capacity_i   (capacity_q),
    .cfg_we_i     (cfg_we_i),
    .cfg_cap_i    (capacity_d),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_re_o     (mem_re),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata),
    .count_o      (count),
    .read_value_o (read_value),
    .flags_o      (flags)
  );

  ale_mem #(
    .DEPTH  (DEPTH),
    .DATA_W (DATA_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // drive the result ports straight from the sequencer registers
  assign busy         = flags.busy;
  assign done_o       = flags.done;
  assign found_o      = flags.found;
  assign status_o     = flags.status;
  assign read_value_o = read_value;
  assign count_o      = count;
  assign is_full_o    = (count == capacity_q);
  assign is_empty_o   = (count == '0);

endmodule

[src/ale_chk.sv]
// Port-level checker for the array list engine, bound to the top level.
module ale_chk #(
  parameter int unsigned DATA_W = ale_pkg::DATA_W_DEF
) (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      start,
  input logic                      busy,
  input logic                      done_o,
  input logic                      found_o,
  input logic signed [DATA_W-1:0]  read_value_o,
  input logic [ale_pkg::STS_W-1:0] status_o
);
  import ale_pkg::*;

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("done strobe held for more than one cycle");

  a_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> $past(done_o))
    else $error("busy dropped without a result");

  a_ok_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (found_o || (read_value_o != '0)) |-> (status_o == ST_OK))
    else $error("data reported with a failing status");

endmodule

bind array_list_engine_unit ale_chk #(.DATA_W(DATA_W)) u_ale_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .done_o       (done_o),
  .found_o      (found_o),
  .read_value_o (read_value_o),
  .status_o     (status_o)
);

[dv/array_list_engine_unit_test.sv]
// Self-checking testbench for the array list engine: command driver, result monitor and list predictor.
`timescale 1ns / 1ps

module array_list_engine_unit_test;
  import ale_pkg::*;

  localparam int unsigned DEPTH  = DEPTH_DEF;
  localparam int unsigned DATA_W = DATA_W_DEF;

  // Opcode 7 has no meaning in the block; it must leave the list alone and report ok.
  localparam logic [OP_W-1:0] OP_SPARE = 3'd7;

  // Generous bound: ~1250 commands, each at most a full walk plus a long sender gap.
  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int unsigned DRAIN_CYCLES = 40;

  // One command as the sender presents it.
  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic [CNT_W-1:0]         pos;
    logic signed [DATA_W-1:0] val;
  } cmd_t;

  // One result as the block reports it.
  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic                     found;
    logic [CNT_W-1:0]         count;
    logic                     is_full;
    logic                     is_empty;
    status_e                  status;
  } reply_t;

  // Predicted contents of the list: every slot past the fill count holds all ones.
  typedef struct packed {
    logic [DEPTH-1:0][DATA_W-1:0] slot;
    logic [CNT_W-1:0]             fill;
    logic [CNT_W-1:0]             cap;
  } list_t;

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     start       = 1'b0;
  logic                     busy;
  logic                     cfg_we_i    = 1'b0;
  logic [CNT_W-1:0]         cfg_wdata_i = '0;
  logic [OP_W-1:0]          opcode_i    = '0;
  logic [CNT_W-1:0]         position_i  = '0;
  logic signed [DATA_W-1:0] value_i     = '0;
  logic                     done_o;
  logic signed [DATA_W-1:0] read_value_o;
  logic                     found_o;
  logic [CNT_W-1:0]         count_o;
  logic                     is_full_o;
  logic                     is_empty_o;
  logic [STS_W-1:0]         status_o;

  array_list_engine_unit #(
    .DEPTH  (DEPTH),
    .DATA_W (DATA_W)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .opcode_i     (opcode_i),
    .position_i   (position_i),
    .value_i      (value_i),
    .done_o       (done_o),
    .read_value_o (read_value_o),
    .found_o      (found_o),
    .count_o      (count_o),
    .is_full_o    (is_full_o),
    .is_empty_o   (is_empty_o),
    .status_o     (status_o)
  );

  always #10 clk_i = ~clk_i;

  // live_list follows the block transaction by transaction; plan_list runs ahead of it
  // while commands are queued, so the generator knows the fill count it will meet.
  list_t       live_list;
  list_t       plan_list;
  cmd_t        cmd_q[$];
  reply_t      reply_q[$];
  cmd_t        on_offer;
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;
  int unsigned mismatches = 0;
  int unsigned cycles     = 0;

  function automatic void list_reset(inout list_t st);
    st.slot = '1;
    st.fill = '0;
    st.cap  = CNT_W'((DEPTH < 5) ? DEPTH : 5);
  endfunction

  // Clamp to 1..DEPTH and drop whatever no longer fits.
  function automatic void list_set_capacity(inout list_t st, input logic [CNT_W-1:0] v);
    int c;
    c = v;
    if (c < 1) c = 1;
    if (c > DEPTH) c = DEPTH;
    st.cap = CNT_W'(c);
    while (st.fill > st.cap) begin
      st.fill = st.fill - 1'b1;
      st.slot[st.fill] = '1;
    end
  endfunction

  // Apply one command to a list and return the result it must produce.
  function automatic reply_t list_apply(inout list_t st, input cmd_t c);
    reply_t r;
    int n;
    int p;
    int cap;
    int i;
    n   = st.fill;
    p   = c.pos;
    cap = st.cap;
    r   = '0;
    r.status = ST_OK;
    case (c.op)
      OP_INSERT: begin
        // a full list is refused before the position is looked at
        if (n >= cap) r.status = ST_FULL;
        else if (p < 1 || p > n + 1) r.status = ST_RANGE;
        else begin
          for (i = n; i > p - 1; i--) st.slot[i] = st.slot[i-1];
          st.slot[p-1] = c.val;
          n++;
        end
      end
      OP_APPEND: begin
        if (n >= cap) r.status = ST_FULL;
        else begin
          st.slot[n] = c.val;
          n++;
        end
      end
      OP_REMOVE: begin
        if (p < 1 || p > n) r.status = ST_RANGE;
        else begin
          for (i = p - 1; i + 1 < n; i++) st.slot[i] = st.slot[i+1];
          n--;
          st.slot[n] = '1;
        end
      end
      OP_GET: begin
        // reads reach every slot up to the capacity, so an unfilled one gives all ones
        if (p < 1 || p > cap) r.status = ST_RANGE;
        else r.read_value = st.slot[p-1];
      end
      OP_UPDATE: begin
        if (p < 1 || p > n) r.status = ST_RANGE;
        else st.slot[p-1] = c.val;
      end
      OP_FIND: begin
        for (i = 0; i < cap; i++)
          if (st.slot[i] == c.val) r.found = 1'b1;
      end
      OP_CLEAR: begin
        st.slot = '1;
        n = 0;
      end
      default: begin
      end
    endcase
    st.fill    = CNT_W'(n);
    r.count    = CNT_W'(n);
    r.is_full  = (n == cap);
    r.is_empty = (n == 0);
    return r;
  endfunction

  // Random command shaped by the planned list: mostly legal positions so that shifts
  // run deep, with stray positions to probe the range checks.
  function automatic cmd_t pick_cmd();
    cmd_t c;
    int r;
    int n;
    int cap;
    n   = plan_list.fill;
    cap = plan_list.cap;
    r   = $urandom_range(99);
    if (r < 24) c.op = OP_INSERT;
    else if (r < 38) c.op = OP_APPEND;
    else if (r < 57) c.op = OP_REMOVE;
    else if (r < 69) c.op = OP_GET;
    else if (r < 80) c.op = OP_UPDATE;
    else if (r < 95) c.op = OP_FIND;
    else if (r < 98) c.op = OP_CLEAR;
    else c.op = OP_SPARE;
    if ($urandom_range(6) == 0) begin
      c.pos = CNT_W'($urandom_range(31));
    end else begin
      case (c.op)
        OP_INSERT: c.pos = CNT_W'($urandom_range(n + 1, 1));
        OP_GET:    c.pos = CNT_W'($urandom_range(cap, 1));
        default:   c.pos = CNT_W'($urandom_range((n > 0) ? n : 1, 1));
      endcase
    end
    // reuse stored words (all ones included) so that find hits often
    r = $urandom_range(9);
    if (r < 4) begin
      c.val = plan_list.slot[$urandom_range(DEPTH - 1)];
    end else if (r < 6) begin
      case ($urandom_range(3))
        0:       c.val = 32'h7FFF_FFFF;
        1:       c.val = 32'h8000_0000;
        2:       c.val = '0;
        default: c.val = '1;
      endcase
    end else begin
      c.val = $urandom;
    end
    return c;
  endfunction

  task automatic queue_cmd(input logic [OP_W-1:0] op, input int p, input logic [DATA_W-1:0] v);
    cmd_t c;
    c.op  = op;
    c.pos = CNT_W'(p);
    c.val = v;
    void'(list_apply(plan_list, c));
    cmd_q.push_back(c);
  endtask

  // Hold until every queued command has been taken and every result has come back.
  // Look at the falling edge, where the sender's and the block's updates have settled.
  task automatic wait_idle();
    while (cmd_q.size() != 0 || start || reply_q.size() != 0 || busy) @(negedge clk_i);
  endtask

  task automatic write_capacity(input logic [CNT_W-1:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    list_set_capacity(live_list, v);
    list_set_capacity(plan_list, v);
  endtask

  task automatic flag_field(input string name, input logic [DATA_W-1:0] want,
                            input logic [DATA_W-1:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Sender: offer the head of the command queue; a transaction is accepted at an edge
  // where start is high and busy is low. Idle in bursts and gaps so that start rises
  // at every point of the block's work, with some back-to-back stretches.
  always @(posedge clk_i) begin : feed
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) reply_q.push_back(list_apply(live_list, on_offer));
      // hold the offer while the block is busy; otherwise move on
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (cmd_q.size() > 0) begin
          on_offer = cmd_q.pop_front();
          start      <= 1'b1;
          opcode_i   <= on_offer.op;
          position_i <= on_offer.pos;
          value_i    <= on_offer.val;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(12);
            gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(24, 1);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Receiver: the block cannot be held off, so take every strobed result and compare
  // it field by field with the oldest prediction.
  always @(posedge clk_i) begin : watch
    reply_t want;
    if (rst_ni && done_o) begin
      if (reply_q.size() == 0) begin
        $display("%0t ns: result with no transaction pending, expected none, actual count %0d",
                 $time, count_o);
        mismatches++;
      end else begin
        want = reply_q.pop_front();
        flag_field("read_value", want.read_value, read_value_o);
        flag_field("found", DATA_W'(want.found), DATA_W'(found_o));
        flag_field("count", DATA_W'(want.count), DATA_W'(count_o));
        flag_field("is_full", DATA_W'(want.is_full), DATA_W'(is_full_o));
        flag_field("is_empty", DATA_W'(want.is_empty), DATA_W'(is_empty_o));
        flag_field("status", DATA_W'(want.status), DATA_W'(status_o));
      end
    end
  end

  // Watchdog: stop a hung run.
  always @(posedge clk_i) begin : watchdog
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin : sequencer
    logic [CNT_W-1:0] caps [10];
    int ph;
    int k;
    caps = '{5'd0, 5'd16, 5'd1, 5'd31, 5'd3, 5'd12, 5'd2, 5'd16, 5'd0, 5'd5};
    caps[8] = CNT_W'($urandom_range(31));
    list_reset(live_list);
    list_reset(plan_list);
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed run at the reset capacity of five.
    queue_cmd(OP_GET, 1, 32'h0);            // unfilled slot reads all ones
    queue_cmd(OP_GET, 0, 32'h0);            // position zero is out of range
    queue_cmd(OP_GET, 6, 32'h0);            // just past the capacity
    queue_cmd(OP_GET, 31, 32'h0);
    queue_cmd(OP_REMOVE, 1, 32'h0);         // nothing to remove
    queue_cmd(OP_UPDATE, 1, 32'h1234);      // nothing to update
    queue_cmd(OP_FIND, 0, 32'hFFFF_FFFF);   // all ones matches the empty slots
    queue_cmd(OP_INSERT, 2, 32'h1);         // beyond count plus one
    queue_cmd(OP_INSERT, 0, 32'h1);
    queue_cmd(OP_INSERT, 1, 32'h7FFF_FFFF);
    queue_cmd(OP_APPEND, 17, 32'h8000_0000); // position ignored
    queue_cmd(OP_INSERT, 3, 32'h0);         // at count plus one
    queue_cmd(OP_INSERT, 1, 32'hFFFF_FFFF);
    queue_cmd(OP_APPEND, 0, 32'h5555_5555); // list now full
    queue_cmd(OP_INSERT, 0, 32'h2);         // full wins over a bad position
    queue_cmd(OP_APPEND, 0, 32'h3);
    queue_cmd(OP_FIND, 0, 32'h8000_0000);
    queue_cmd(OP_FIND, 0, 32'h0001_E240);
    queue_cmd(OP_UPDATE, 5, 32'hAAAA_AAAA);
    queue_cmd(OP_UPDATE, 6, 32'h4);
    queue_cmd(OP_REMOVE, 1, 32'h0);
    queue_cmd(OP_REMOVE, 4, 32'h0);         // last entry
    queue_cmd(OP_GET, 5, 32'h0);            // freed slot reads all ones
    queue_cmd(OP_SPARE, 16, 32'hDEAD_BEEF); // unused opcode
    queue_cmd(OP_CLEAR, 0, 32'h0);
    wait_idle();
    repeat (4) @(posedge clk_i);

    // Random phases, each under its own capacity; shrinking a full list drops entries.
    for (ph = 0; ph < 10; ph++) begin
      write_capacity(caps[ph]);
      for (k = 0; k < 120; k++) begin
        cmd_t c;
        c = pick_cmd();
        queue_cmd(c.op, c.pos, c.val);
      end
      wait_idle();
      repeat (4) @(posedge clk_i);
    end

    // Drain: give a stray late result time to show up.
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && reply_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[filelist.f]
src/ale_pkg.sv
src/ale_mem.sv
src/ale_seq.sv
src/array_list_engine_unit.sv
src/ale_chk.sv
dv/array_list_engine_unit_test.sv
